// File: sv/s2ch_pkg.sv
// Package: types and codes shared by the SSLv2 client hello detector.
`timescale 1ns / 1ps
`default_nettype none
package s2ch_pkg;

	localparam int unsigned RecLenW = 15;
	localparam logic [RecLenW-1:0] HdrLen = 15'd9;
	localparam logic [7:0] MsgClientHello = 8'h01;
	localparam logic [7:0] MaxVersion = 8'h03;

	// verdict codes on the result channel
	typedef enum logic [1:0] {
		VERDICT_CHECKING = 2'd0,
		VERDICT_FOUND    = 2'd1,
		VERDICT_NOTFOUND = 2'd2
	} verdict_t;

	// header parse position, one-hot
	typedef enum logic [12:0] {
		PH_LEN_HI   = 13'b0000000000001,
		PH_LEN_LO   = 13'b0000000000010,
		PH_MSG_TYPE = 13'b0000000000100,
		PH_VER_MAJ  = 13'b0000000001000,
		PH_VER_MIN  = 13'b0000000010000,
		PH_CS_HI    = 13'b0000000100000,
		PH_CS_LO    = 13'b0000001000000,
		PH_SID_HI   = 13'b0000010000000,
		PH_SID_LO   = 13'b0000100000000,
		PH_CH_HI    = 13'b0001000000000,
		PH_CH_LO    = 13'b0010000000000,
		PH_FOUND    = 13'b0100000000000,
		PH_NOTFOUND = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       flow_start;
	} item_t;

endpackage
`default_nettype wire

// File: sv/s2ch_if.sv
// Interfaces: payload byte channel and verdict channel.
`timescale 1ns / 1ps
`default_nettype none
interface s2ch_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       flow_start;

	modport source (output valid, output data_byte, output flow_start, input ready);
	modport sink (input valid, input data_byte, input flow_start, output ready);
endinterface

interface s2ch_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface
`default_nettype wire

// File: sv/s2ch_in_stage.sv
// Input register stage for payload words.
`timescale 1ns / 1ps
`default_nettype none
module s2ch_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	s2ch_byte_if.sink          payload,
	input  wire logic          advance,
	output logic               valid_s1,
	output s2ch_pkg::item_t    item_s1
);

	assign payload.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.ready) begin
			valid_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.valid && payload.ready) begin
			item_s1.data_byte  <= payload.data_byte;
			item_s1.flow_start <= payload.flow_start;
		end
	end

endmodule
`default_nettype wire

// File: sv/s2ch_tracker.sv
// Header parse state and next-state logic; gives the verdict for the staged word.
`timescale 1ns / 1ps
`default_nettype none
module s2ch_tracker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire s2ch_pkg::item_t   item_s1,
	output s2ch_pkg::verdict_t     verdict
);

	s2ch_pkg::phase_t                  phase_q, cur_phase, nxt_phase;
	logic [s2ch_pkg::RecLenW-1:0]      rem_q, cur_rem, nxt_rem;
	logic [7:0]                        hi_q, cur_hi, nxt_hi;
	logic [s2ch_pkg::RecLenW-1:0]      full_len;
	logic [15:0]                       len16;
	logic                              len_fits;
	logic [7:0]                        b;

	assign b         = item_s1.data_byte;
	assign cur_phase = item_s1.flow_start ? s2ch_pkg::PH_LEN_HI : phase_q;
	assign cur_rem   = item_s1.flow_start ? '0 : rem_q;
	assign cur_hi    = item_s1.flow_start ? '0 : hi_q;

	assign full_len = cur_rem | {{(s2ch_pkg::RecLenW-8){1'b0}}, b};
	assign len16    = {cur_hi, b};
	assign len_fits = {1'b0, cur_rem} >= len16;

	always_comb begin
		nxt_phase = cur_phase;
		nxt_rem   = cur_rem;
		nxt_hi    = cur_hi;
		case (cur_phase)
			s2ch_pkg::PH_LEN_HI: begin
				if (!b[7]) begin
					nxt_phase = s2ch_pkg::PH_NOTFOUND;
				end else begin
					nxt_rem   = {b[6:0], 8'h00};
					nxt_phase = s2ch_pkg::PH_LEN_LO;
				end
			end
			s2ch_pkg::PH_LEN_LO: begin
				if (full_len < s2ch_pkg::HdrLen) begin
					nxt_phase = s2ch_pkg::PH_NOTFOUND;
				end else begin
					nxt_rem   = full_len - s2ch_pkg::HdrLen;
					nxt_phase = s2ch_pkg::PH_MSG_TYPE;
				end
			end
			s2ch_pkg::PH_MSG_TYPE: begin
				nxt_phase = (b == s2ch_pkg::MsgClientHello) ? s2ch_pkg::PH_VER_MAJ
				                                            : s2ch_pkg::PH_NOTFOUND;
			end
			s2ch_pkg::PH_VER_MAJ: begin
				nxt_phase = (b <= s2ch_pkg::MaxVersion) ? s2ch_pkg::PH_VER_MIN
				                                        : s2ch_pkg::PH_NOTFOUND;
			end
			s2ch_pkg::PH_VER_MIN: begin
				nxt_phase = (b <= s2ch_pkg::MaxVersion) ? s2ch_pkg::PH_CS_HI
				                                        : s2ch_pkg::PH_NOTFOUND;
			end
			s2ch_pkg::PH_CS_HI: begin
				nxt_hi    = b;
				nxt_phase = s2ch_pkg::PH_CS_LO;
			end
			s2ch_pkg::PH_SID_HI: begin
				nxt_hi    = b;
				nxt_phase = s2ch_pkg::PH_SID_LO;
			end
			s2ch_pkg::PH_CH_HI: begin
				nxt_hi    = b;
				nxt_phase = s2ch_pkg::PH_CH_LO;
			end
			s2ch_pkg::PH_CS_LO: begin
				if (!len_fits) begin
					nxt_phase = s2ch_pkg::PH_NOTFOUND;
				end else begin
					nxt_rem   = cur_rem - len16[s2ch_pkg::RecLenW-1:0];
					nxt_phase = s2ch_pkg::PH_SID_HI;
				end
			end
			s2ch_pkg::PH_SID_LO: begin
				if (!len_fits) begin
					nxt_phase = s2ch_pkg::PH_NOTFOUND;
				end else begin
					nxt_rem   = cur_rem - len16[s2ch_pkg::RecLenW-1:0];
					nxt_phase = s2ch_pkg::PH_CH_HI;
				end
			end
			s2ch_pkg::PH_CH_LO: begin
				// challenge length is only checked, not consumed
				nxt_phase = len_fits ? s2ch_pkg::PH_FOUND : s2ch_pkg::PH_NOTFOUND;
			end
			s2ch_pkg::PH_FOUND: begin
				nxt_phase = s2ch_pkg::PH_FOUND;
			end
			default: begin
				nxt_phase = s2ch_pkg::PH_NOTFOUND;
			end
		endcase
	end

	always_comb begin
		case (nxt_phase)
			s2ch_pkg::PH_FOUND:    verdict = s2ch_pkg::VERDICT_FOUND;
			s2ch_pkg::PH_NOTFOUND: verdict = s2ch_pkg::VERDICT_NOTFOUND;
			default:               verdict = s2ch_pkg::VERDICT_CHECKING;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= s2ch_pkg::PH_LEN_HI;
			rem_q   <= '0;
			hi_q    <= '0;
		end else if (advance) begin
			phase_q <= nxt_phase;
			rem_q   <= nxt_rem;
			hi_q    <= nxt_hi;
		end
	end

endmodule
`default_nettype wire

// File: sv/sslv2_client_hello_detector_core.sv
// A word is registered in the input stage, then its verdict in the output register.
// One word per cycle unless the result channel stalls; parse state updates once per word.
// The output register holds a waiting verdict; the input stage can still take one word.
// Reset: arst_n clears the parse state to the first length byte and empties both stages.
// Top level: SSLv2 client hello header detector.
`timescale 1ns / 1ps
`default_nettype none
module sslv2_client_hello_detector_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	s2ch_byte_if.sink        payload,
	s2ch_verdict_if.source   result
);

	logic                  valid_s1;
	s2ch_pkg::item_t       item_s1;
	logic                  advance;
	s2ch_pkg::verdict_t    verdict;
	logic                  out_valid_q;
	logic [1:0]            verdict_q;

	assign advance = valid_s1 && (!out_valid_q || result.ready);

	s2ch_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.payload  (payload),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	s2ch_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q <= verdict;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.verdict = verdict_q;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the SSLv2 client hello detector: random byte flows, verdict scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import s2ch_pkg::*;

	typedef struct {
		logic [7:0] data_byte;
		logic       flow_start;
		bit         drain;
	} stim_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	s2ch_byte_if    pay ();
	s2ch_verdict_if res ();

	sslv2_client_hello_detector_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.payload(pay),
		.result (res)
	);

	stim_word_t byte_q[$];
	verdict_t   verdict_q[$];
	int         err_cnt = 0;
	int         gap_cnt = 0;
	int         stall_cnt = 0;
	bit         quiet = 1'b0;
	bit         in_taken = 1'b0;

	// parse state of the predictor
	phase_t             hdr_phase;
	logic [RecLenW-1:0] rec_left;
	logic [7:0]         len_hi;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		pay.valid = 1'b0;
		pay.data_byte = '0;
		pay.flow_start = 1'b0;
		res.ready = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic verdict_t next_verdict(input logic [7:0] b, input logic fs);
		logic [15:0] full;
		logic [15:0] len16;
		if (fs) begin
			hdr_phase = PH_LEN_HI;
			rec_left = '0;
			len_hi = '0;
		end
		case (hdr_phase)
			PH_LEN_HI: begin
				if (!b[7])
					hdr_phase = PH_NOTFOUND;
				else begin
					rec_left = {b[6:0], 8'h00};
					hdr_phase = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				full = {1'b0, rec_left | {7'd0, b}};
				if (full < {1'b0, HdrLen})
					hdr_phase = PH_NOTFOUND;
				else begin
					rec_left = full[14:0] - HdrLen;
					hdr_phase = PH_MSG_TYPE;
				end
			end
			PH_MSG_TYPE: hdr_phase = (b == MsgClientHello) ? PH_VER_MAJ : PH_NOTFOUND;
			PH_VER_MAJ: hdr_phase = (b <= MaxVersion) ? PH_VER_MIN : PH_NOTFOUND;
			PH_VER_MIN: hdr_phase = (b <= MaxVersion) ? PH_CS_HI : PH_NOTFOUND;
			PH_CS_HI, PH_SID_HI, PH_CH_HI: begin
				len_hi = b;
				hdr_phase = phase_t'(hdr_phase << 1);
			end
			PH_CS_LO, PH_SID_LO, PH_CH_LO: begin
				len16 = {len_hi, b};
				if ({1'b0, rec_left} < len16)
					hdr_phase = PH_NOTFOUND;
				else if (hdr_phase == PH_CH_LO)
					hdr_phase = PH_FOUND;
				else begin
					rec_left = rec_left - len16[14:0];
					hdr_phase = phase_t'(hdr_phase << 1);
				end
			end
			PH_FOUND: ;
			default: hdr_phase = PH_NOTFOUND;
		endcase
		if (hdr_phase == PH_FOUND)
			return VERDICT_FOUND;
		if (hdr_phase == PH_NOTFOUND)
			return VERDICT_NOTFOUND;
		return VERDICT_CHECKING;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		err_cnt++;
	endtask

	task automatic add_word(input logic [7:0] b, input logic fs, input bit drain = 1'b0);
		stim_word_t w;
		w.data_byte = b;
		w.flow_start = fs;
		w.drain = drain;
		byte_q.push_back(w);
	endtask

	// length field: mostly fits, sometimes exactly equal, sometimes one over or wild
	function automatic logic [15:0] pick_len(input logic [15:0] avail);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return avail;
		if (r < 18)
			return avail + 16'd1;
		if (r < 22)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, avail));
	endfunction

	// one flow header with random content and trailing bytes; returns words queued
	task automatic add_flow(output int n);
		logic [14:0] rec;
		logic [15:0] avail;
		logic [15:0] fld;
		logic [7:0]  hdr[11];
		int          k;
		int          extra;
		rec = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 40))
		                                  : 15'($urandom_range(0, 32767));
		hdr[0] = {1'b1, rec[14:8]};
		hdr[1] = rec[7:0];
		hdr[2] = MsgClientHello;
		hdr[3] = 8'($urandom_range(0, 3));
		hdr[4] = 8'($urandom_range(0, 3));
		avail = (rec >= 15'd9) ? {1'b0, rec - 15'd9} : 16'd0;
		for (k = 0; k < 3; k++) begin
			fld = pick_len(avail);
			hdr[5 + 2 * k] = fld[15:8];
			hdr[6 + 2 * k] = fld[7:0];
			if (fld <= avail)
				avail = avail - fld;
		end
		if ($urandom_range(0, 99) < 12)
			hdr[$urandom_range(0, 10)] = 8'($urandom);
		n = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 10) : 11;
		for (k = 0; k < n; k++)
			add_word(hdr[k], k == 0);
		extra = $urandom_range(0, 3);
		repeat (extra)
			add_word(8'($urandom), 1'b0);
		n += extra;
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!pay.valid || in_taken)) begin
			in_taken = 1'b0;
			if (gap_cnt > 0) begin
				gap_cnt--;
				pay.valid <= 1'b0;
			end else if (byte_q.size() > 0 && !(byte_q[0].drain && verdict_q.size() != 0)) begin
				pay.data_byte <= byte_q[0].data_byte;
				pay.flow_start <= byte_q[0].flow_start;
				pay.valid <= 1'b1;
				void'(byte_q.pop_front());
				gap_cnt = pick_gap();
				if ($urandom_range(0, 299) == 0)
					quiet = !quiet;
			end else begin
				pay.valid <= 1'b0;
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_cnt > 0) begin
				stall_cnt--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_cnt = pick_gap();
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0)
					report_mismatch($sformatf("verdict %0d with none pending", res.verdict));
				else begin
					if (res.verdict !== verdict_q[0])
						report_mismatch($sformatf("verdict got %0d want %0d",
							res.verdict, verdict_q[0]));
					void'(verdict_q.pop_front());
				end
			end
			if (pay.valid && pay.ready) begin
				verdict_q.push_back(next_verdict(pay.data_byte, pay.flow_start));
				in_taken = 1'b1;
			end
		end
	end

	initial begin
		int total;
		int n;
		bit mid_drain;
		hdr_phase = PH_LEN_HI;
		rec_left = '0;
		len_hi = '0;
		total = 0;
		mid_drain = 1'b0;

		// max record length, cipher length equal to what is left, then a found verdict
		add_word(8'hFF, 1'b0);
		add_word(8'hFF, 1'b0);
		add_word(8'h01, 1'b0);
		add_word(8'h03, 1'b0);
		add_word(8'h03, 1'b0);
		add_word(8'h7F, 1'b0);
		add_word(8'hF6, 1'b0);
		add_word(8'h00, 1'b0);
		add_word(8'h00, 1'b0);
		add_word(8'h00, 1'b0);
		add_word(8'h00, 1'b0);
		add_word(8'h00, 1'b0); // settled: ignored
		add_word(8'h00, 1'b1); // new flow, top bit clear
		add_word(8'h80, 1'b1); // length 8: too short
		add_word(8'h08, 1'b0);
		add_word(8'h80, 1'b1); // length 9, bad message type
		add_word(8'h09, 1'b0);
		add_word(8'h02, 1'b0);
		add_word(8'h80, 1'b1); // bad major version
		add_word(8'h09, 1'b0);
		add_word(8'h01, 1'b0);
		add_word(8'h04, 1'b0);
		add_word(8'h80, 1'b1); // restart mid header
		add_word(8'h80, 1'b1);
		add_word(8'h0A, 1'b0);

		// sender holds until the directed part has fully drained
		add_word(8'h80, 1'b1, 1'b1);
		total = 1;
		while (total < 1900) begin
			if ($urandom_range(0, 99) < 5) begin
				repeat ($urandom_range(1, 6)) begin
					add_word(8'($urandom), 1'($urandom));
					total++;
				end
			end else begin
				add_flow(n);
				total += n;
			end
			if (!mid_drain && total > 950) begin
				add_word(8'($urandom), 1'b1, 1'b1);
				total++;
				mid_drain = 1'b1;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || pay.valid)
			@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0)
			report_mismatch("verdicts left over");
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
sv/s2ch_pkg.sv
sv/s2ch_if.sv
sv/s2ch_in_stage.sv
sv/s2ch_tracker.sv
sv/sslv2_client_hello_detector_core.sv
verif/tb_top.sv
